// ===== sv/headset_jack_hook_detector_unit_defines.svh =====
// Assertion macros shared by the detector RTL.
// No dependencies; the using module must provide clk and arst_n.
`ifndef HEADSET_JACK_HOOK_DETECTOR_UNIT_DEFINES_SVH
`define HEADSET_JACK_HOOK_DETECTOR_UNIT_DEFINES_SVH
`ifndef SYNTH
`define HJHD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hjhd: same-cycle check failed");
`define HJHD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hjhd: next-cycle check failed");
`else
`define HJHD_ASSERT_IMPL(lbl, ante, cons)
`define HJHD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/hjhd_pkg.sv =====
// Shared types, constants and helpers for the headset jack/hook detector.
// No dependencies.
package hjhd_pkg;

	localparam int TIMER_BITS     = 10;
	localparam int STABLE_WINDOWS = 3;
	localparam int CFG_W          = 10;
	localparam int IDX_W          = 3;
	localparam int unsigned TIMER_MAX = (1 << TIMER_BITS) - 1;

	localparam logic [1:0] SW_HEADSET = 2'b01;
	localparam logic [1:0] SW_NO_MIC  = 2'b10;

	typedef logic [TIMER_BITS-1:0] timer_t;

	typedef enum logic [IDX_W-1:0] {
		REG_INSERT_ACTIVE_HIGH,
		REG_HOOK_LINE_PRESENT,
		REG_DETECT_DELAY,
		REG_MIC_DELAY,
		REG_MIC_RETRY_DELAY,
		REG_HOOK_DELAY,
		REG_STABLE_WINDOW
	} reg_idx_t;

	typedef struct packed {
		logic             insert_active_high;
		logic             hook_line_present;
		logic [CFG_W-1:0] detect_delay;
		logic [CFG_W-1:0] mic_delay;
		logic [CFG_W-1:0] mic_retry_delay;
		logic [CFG_W-1:0] hook_delay;
		logic [CFG_W-1:0] stable_window;
	} cfg_t;

	// next-tick view of the jack/mic side, consumed by the hook probe and result register
	typedef struct packed {
		logic       plugged;
		logic       hook_armed;
		logic       report;
		logic [1:0] report_bits;
	} jack_status_t;

	// zero loads as one, values beyond the timer saturate
	function automatic timer_t load_val(logic [CFG_W-1:0] v);
		logic [31:0] wide;
		wide = 32'(v);
		if (wide == 32'd0)
			wide = 32'd1;
		if (wide > 32'(TIMER_MAX))
			wide = 32'(TIMER_MAX);
		return wide[TIMER_BITS-1:0];
	endfunction

	function automatic timer_t count_down(timer_t t);
		return (t != '0) ? t - 1'b1 : '0;
	endfunction

	// window counter after one more stable window: true when the check is done
	function automatic logic window_done(logic [1:0] win_next);
		return (32'(win_next) >= STABLE_WINDOWS) || (win_next == 2'd0);
	endfunction

endpackage

// ===== sv/hjhd_cfg.sv =====
// Configuration register file of the detector.
// Depends on hjhd_pkg.
module hjhd_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [hjhd_pkg::IDX_W-1:0] cfg_index,
	input  logic [hjhd_pkg::CFG_W-1:0] cfg_data,
	output hjhd_pkg::cfg_t             cfg
);

	hjhd_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.insert_active_high <= 1'b1;
			cfg_q.hook_line_present  <= 1'b1;
			cfg_q.detect_delay       <= hjhd_pkg::CFG_W'(200);
			cfg_q.mic_delay          <= hjhd_pkg::CFG_W'(300);
			cfg_q.mic_retry_delay    <= hjhd_pkg::CFG_W'(500);
			cfg_q.hook_delay         <= hjhd_pkg::CFG_W'(120);
			cfg_q.stable_window      <= hjhd_pkg::CFG_W'(80);
		end else if (cfg_valid) begin
			case (hjhd_pkg::reg_idx_t'(cfg_index))
				hjhd_pkg::REG_INSERT_ACTIVE_HIGH: cfg_q.insert_active_high <= cfg_data[0];
				hjhd_pkg::REG_HOOK_LINE_PRESENT:  cfg_q.hook_line_present  <= cfg_data[0];
				hjhd_pkg::REG_DETECT_DELAY:       cfg_q.detect_delay       <= cfg_data;
				hjhd_pkg::REG_MIC_DELAY:          cfg_q.mic_delay          <= cfg_data;
				hjhd_pkg::REG_MIC_RETRY_DELAY:    cfg_q.mic_retry_delay    <= cfg_data;
				hjhd_pkg::REG_HOOK_DELAY:         cfg_q.hook_delay         <= cfg_data;
				hjhd_pkg::REG_STABLE_WINDOW:      cfg_q.stable_window      <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/hjhd_jack.sv =====
// Mic probe and jack debounce: switch state, headset flag and hook arming.
// Depends on hjhd_pkg.
module hjhd_jack (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  hjhd_pkg::cfg_t        cfg,
	input  logic                  jack_level,
	input  logic                  hook_level,
	input  logic                  codec_ready,
	output hjhd_pkg::jack_status_t status
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DELAY,
		PH_WINDOW
	} phase_t;

	phase_t           mic_phase_q, mic_phase_d;
	hjhd_pkg::timer_t mic_timer_q, mic_timer_d, mic_dec;
	hjhd_pkg::timer_t jack_timer_q, jack_timer_d, jack_dec;
	logic [1:0]       mic_window_q, mic_window_d, win_next;
	logic [1:0]       report_bits_q, report_bits_d;
	logic             mic_ref_q, mic_ref_d;
	logic             prev_jack_q, jack_pending_q, jack_pending_d;
	logic             plugged_q, plugged_d;
	logic             hook_armed_q, hook_armed_d;
	logic             report, ins;

	always_comb begin
		mic_phase_d    = mic_phase_q;
		mic_timer_d    = mic_timer_q;
		mic_window_d   = mic_window_q;
		mic_ref_d      = mic_ref_q;
		jack_timer_d   = jack_timer_q;
		jack_pending_d = jack_pending_q;
		plugged_d      = plugged_q;
		hook_armed_d   = hook_armed_q;
		report_bits_d  = report_bits_q;
		report         = 1'b0;
		mic_dec        = hjhd_pkg::count_down(mic_timer_q);
		jack_dec       = hjhd_pkg::count_down(jack_timer_q);
		win_next       = mic_window_q + 2'd1;
		ins            = (jack_level == cfg.insert_active_high);

		// mic probe runs first within a tick
		case (mic_phase_q)
			PH_DELAY: begin
				mic_timer_d = mic_dec;
				if (mic_dec == '0) begin
					if (!plugged_q) begin
						report_bits_d = 2'b00;
						report        = 1'b1;
						mic_phase_d   = PH_IDLE;
					end else if (!codec_ready) begin
						mic_timer_d = hjhd_pkg::load_val(cfg.mic_retry_delay);
					end else begin
						mic_ref_d    = hook_level;
						mic_window_d = 2'd0;
						mic_timer_d  = hjhd_pkg::load_val(cfg.stable_window);
						mic_phase_d  = PH_WINDOW;
					end
				end
			end
			PH_WINDOW: begin
				mic_timer_d = mic_dec;
				if (mic_dec == '0) begin
					if (hook_level != mic_ref_q) begin
						mic_phase_d = PH_IDLE;
					end else begin
						mic_window_d = win_next;
						if (hjhd_pkg::window_done(win_next)) begin
							mic_phase_d = PH_IDLE;
							if (!mic_ref_q) begin
								report_bits_d = report_bits_d | hjhd_pkg::SW_NO_MIC;
								if (cfg.hook_line_present)
									hook_armed_d = 1'b1;
							end else begin
								hook_armed_d  = 1'b1;
								report_bits_d = report_bits_d & ~hjhd_pkg::SW_NO_MIC;
							end
							if (!cfg.hook_line_present)
								report_bits_d = report_bits_d | hjhd_pkg::SW_NO_MIC;
							report = 1'b1;
						end else begin
							mic_timer_d = hjhd_pkg::load_val(cfg.stable_window);
						end
					end
				end
			end
			default: mic_phase_d = PH_IDLE;
		endcase

		// jack debounce: later edges are ignored while a delay runs
		if (jack_pending_q) begin
			jack_timer_d = jack_dec;
			if (jack_dec == '0) begin
				jack_pending_d = 1'b0;
				if (ins != plugged_q) begin
					plugged_d = ins;
					if (ins) begin
						report_bits_d = hjhd_pkg::SW_HEADSET;
						if (cfg.hook_line_present) begin
							if (mic_phase_d == PH_IDLE) begin
								mic_phase_d = PH_DELAY;
								mic_timer_d = hjhd_pkg::load_val(cfg.mic_delay);
							end
						end else begin
							report_bits_d = report_bits_d | hjhd_pkg::SW_NO_MIC;
							report        = 1'b1;
						end
					end else begin
						hook_armed_d  = 1'b0;
						report_bits_d = 2'b00;
						report        = 1'b1;
					end
				end
			end
		end else if (jack_level != prev_jack_q) begin
			jack_pending_d = 1'b1;
			jack_timer_d   = hjhd_pkg::load_val(cfg.detect_delay);
		end
	end

	assign status.plugged     = plugged_d;
	assign status.hook_armed  = hook_armed_d;
	assign status.report      = report;
	assign status.report_bits = report_bits_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mic_phase_q    <= PH_IDLE;
			mic_timer_q    <= '0;
			mic_window_q   <= 2'd0;
			mic_ref_q      <= 1'b0;
			prev_jack_q    <= 1'b0;
			jack_timer_q   <= '0;
			jack_pending_q <= 1'b0;
			plugged_q      <= 1'b0;
			hook_armed_q   <= 1'b0;
			report_bits_q  <= 2'b00;
		end else if (step) begin
			mic_phase_q    <= mic_phase_d;
			mic_timer_q    <= mic_timer_d;
			mic_window_q   <= mic_window_d;
			mic_ref_q      <= mic_ref_d;
			prev_jack_q    <= jack_level;
			jack_timer_q   <= jack_timer_d;
			jack_pending_q <= jack_pending_d;
			plugged_q      <= plugged_d;
			hook_armed_q   <= hook_armed_d;
			report_bits_q  <= report_bits_d;
		end
	end

endmodule

// ===== sv/hjhd_hook.sv =====
// Hook key probe: debounced press/release events.
// Depends on hjhd_pkg; uses the next-tick jack status from hjhd_jack.
module hjhd_hook (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  hjhd_pkg::cfg_t        cfg,
	input  logic                  hook_level,
	input  logic                  codec_ready,
	input  hjhd_pkg::jack_status_t status,
	output logic                  key_event,
	output logic                  key_pressed
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DELAY,
		PH_WINDOW
	} phase_t;

	phase_t           hook_phase_q, hook_phase_d;
	hjhd_pkg::timer_t hook_timer_q, hook_timer_d, hook_dec;
	logic [1:0]       hook_window_q, hook_window_d, win_next;
	logic             hook_ref_q, hook_ref_d;
	logic             key_down_q, key_down_d;
	logic             prev_hook_q;

	always_comb begin
		hook_phase_d  = hook_phase_q;
		hook_timer_d  = hook_timer_q;
		hook_window_d = hook_window_q;
		hook_ref_d    = hook_ref_q;
		key_down_d    = key_down_q;
		key_event     = 1'b0;
		key_pressed   = 1'b0;
		hook_dec      = hjhd_pkg::count_down(hook_timer_q);
		win_next      = hook_window_q + 2'd1;

		case (hook_phase_q)
			PH_DELAY: begin
				hook_timer_d = hook_dec;
				if (hook_dec == '0) begin
					if (!status.plugged || !codec_ready) begin
						hook_phase_d = PH_IDLE;
					end else begin
						hook_ref_d    = hook_level;
						hook_window_d = 2'd0;
						hook_timer_d  = hjhd_pkg::load_val(cfg.stable_window);
						hook_phase_d  = PH_WINDOW;
					end
				end
			end
			PH_WINDOW: begin
				hook_timer_d = hook_dec;
				if (hook_dec == '0) begin
					if (hook_level != hook_ref_q) begin
						hook_phase_d = PH_IDLE;
					end else begin
						hook_window_d = win_next;
						if (hjhd_pkg::window_done(win_next)) begin
							hook_phase_d = PH_IDLE;
							// line low means pressed
							if (!hook_ref_q != key_down_q) begin
								key_down_d  = !hook_ref_q;
								key_event   = 1'b1;
								key_pressed = !hook_ref_q;
							end
						end else begin
							hook_timer_d = hjhd_pkg::load_val(cfg.stable_window);
						end
					end
				end
			end
			default: begin
				hook_phase_d = PH_IDLE;
				if (status.hook_armed && cfg.hook_line_present && hook_level != prev_hook_q) begin
					hook_phase_d = PH_DELAY;
					hook_timer_d = hjhd_pkg::load_val(cfg.hook_delay);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hook_phase_q  <= PH_IDLE;
			hook_timer_q  <= '0;
			hook_window_q <= 2'd0;
			hook_ref_q    <= 1'b0;
			key_down_q    <= 1'b0;
			prev_hook_q   <= 1'b1;
		end else if (step) begin
			hook_phase_q  <= hook_phase_d;
			hook_timer_q  <= hook_timer_d;
			hook_window_q <= hook_window_d;
			hook_ref_q    <= hook_ref_d;
			key_down_q    <= key_down_d;
			prev_hook_q   <= hook_level;
		end
	end

endmodule

// ===== sv/headset_jack_hook_detector_unit.sv =====
// Headset jack / hook key detector, top level.
// Depends on hjhd_pkg, hjhd_cfg, hjhd_jack, hjhd_hook and the assertion macro header.
//
// Usage:
//  - Input channel (in_valid/in_stall): one beat per millisecond tick carrying
//    jack_level, hook_level and codec_ready.
//  - Output channel (out_valid/out_stall): exactly one result beat per input
//    beat, in order: switch bits, report/key pulses, speaker_on, hook_enabled.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): cfg_ready is
//    always high; write registers only while no tick is in flight.
// Pipeline: a beat is registered in the input stage and is evaluated on its way
// into the result register, which drives out_valid; while out_stall holds a
// waiting result, the beat stays in the input stage.
// Throughput: one tick per cycle unless out_stall holds a result; the evaluation
// is a single pass of counter decrements and flag updates between the two registers.
// Stall: when out_stall holds a waiting result, the input stage still takes
// one more beat; in_stall rises only when both stages are full.
// Reset (arst_n low): all detector state returns to headset out, hook up,
// probes idle, and the config registers return to their default values.
module headset_jack_hook_detector_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	// tick input
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       jack_level,
	input  logic                       hook_level,
	input  logic                       codec_ready,
	// result output
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       headset_present,
	output logic                       no_mic,
	output logic                       state_report,
	output logic                       key_event,
	output logic                       key_pressed,
	output logic                       speaker_on,
	output logic                       hook_enabled,
	// configuration writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [hjhd_pkg::IDX_W-1:0] cfg_index,
	input  logic [hjhd_pkg::CFG_W-1:0] cfg_data
);

`include "headset_jack_hook_detector_unit_defines.svh"

	hjhd_pkg::cfg_t         cfg;
	hjhd_pkg::jack_status_t status;

	// input stage
	logic valid_s1;
	logic jack_level_s1, hook_level_s1, codec_ready_s1;

	// result register
	logic out_valid_q;
	logic headset_present_q, no_mic_q, state_report_q;
	logic key_event_q, key_pressed_q, speaker_on_q, hook_enabled_q;

	logic advance, in_take;
	logic key_event_c, key_pressed_c;

	// stage 1 moves into the result register when that is empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	hjhd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hjhd_jack u_jack (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.cfg         (cfg),
		.jack_level  (jack_level_s1),
		.hook_level  (hook_level_s1),
		.codec_ready (codec_ready_s1),
		.status      (status)
	);

	hjhd_hook u_hook (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.cfg         (cfg),
		.hook_level  (hook_level_s1),
		.codec_ready (codec_ready_s1),
		.status      (status),
		.key_event   (key_event_c),
		.key_pressed (key_pressed_c)
	);

	// handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			jack_level_s1  <= jack_level;
			hook_level_s1  <= hook_level;
			codec_ready_s1 <= codec_ready;
		end
		if (advance) begin
			headset_present_q <= status.report_bits[0];
			no_mic_q          <= status.report_bits[1];
			state_report_q    <= status.report;
			key_event_q       <= key_event_c;
			key_pressed_q     <= key_pressed_c;
			speaker_on_q      <= (status.report_bits == 2'b00);
			hook_enabled_q    <= status.hook_armed;
		end
	end

	assign out_valid       = out_valid_q;
	assign headset_present = headset_present_q;
	assign no_mic          = no_mic_q;
	assign state_report    = state_report_q;
	assign key_event       = key_event_q;
	assign key_pressed     = key_pressed_q;
	assign speaker_on      = speaker_on_q;
	assign hook_enabled    = hook_enabled_q;

	// a blocked tick stays in stage 1
	`HJHD_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1)
	// an accepted tick always lands in stage 1
	`HJHD_ASSERT_NEXT(a_s1_fill, in_take, valid_s1)
	// a drained result with nothing behind it leaves the output empty
	`HJHD_ASSERT_NEXT(a_out_drain, out_valid_q && !out_stall && !advance, !out_valid_q)
	// press flag only rides along with a key event
	`HJHD_ASSERT_IMPL(a_key_quiet, out_valid_q && !key_event_q, !key_pressed_q)

endmodule
